// ===== hw/rtl/h264_sps_size_parser_core_defines.svh =====
// assertion macros for the sps size parser core
`ifndef H264_SPS_SIZE_PARSER_CORE_DEFINES_SVH
`define H264_SPS_SIZE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HSPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hspp check failed");

// next-cycle implication, checked outside reset
`define HSPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hspp check failed");

`endif

// ===== hw/rtl/hspp_pkg.sv =====
// types, constants and helpers shared by the sps size parser
`default_nettype none

package hspp_pkg;

  localparam logic [13:0] MAX_WIDTH_RST  = 14'd640;
  localparam logic [13:0] MAX_HEIGHT_RST = 14'd480;
  localparam logic [3:0]  SHORT_BYTES    = 4'd8;

  localparam logic CFG_MAX_WIDTH  = 1'b0;
  localparam logic CFG_MAX_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    PH_HDR, PH_PROFILE, PH_FLAGS, PH_LEVEL, PH_SPS_ID, PH_LOG2FN, PH_POC_TYPE,
    PH_POC_LSB, PH_NUM_REF, PH_GAPS, PH_MB_W, PH_MB_H, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK, ST_SHORT, ST_CODE, ST_UNSUP
  } status_e;

  typedef struct packed {
    logic valid;
    logic value;
    logic byte_end;
  } bit_t;

  typedef struct packed {
    logic [13:0] width;
    logic [13:0] height;
    logic [7:0]  level;
    logic [7:0]  profile;
    status_e     status;
  } result_t;

  // profiles whose sps carries chroma format fields
  function automatic logic high_profile(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
           p == 8'd44  || p == 8'd83  || p == 8'd86  || p == 8'd118 ||
           p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
           p == 8'd135;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hspp_bit_feed.sv =====
// byte input register that shifts each byte out one bit per cycle, msb first
`default_nettype none

module hspp_bit_feed import hspp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  output logic            byte_ready_o,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output bit_t            bit_o,
  output logic            fin_valid_o,
  input  wire logic       fin_ready_i
);

  logic [7:0] sh_q, sh_d;
  logic [3:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       fin_q, fin_d;

  assign byte_ready_o = (cnt_q == 4'd0) && !fin_q;
  assign fin_valid_o  = fin_q;

  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    fin_d  = fin_q;
    bit_o.valid    = 1'b0;
    bit_o.value    = sh_q[7];
    bit_o.byte_end = (cnt_q == 4'd1);
    if (fin_q && fin_ready_i) begin
      fin_d = 1'b0;
    end
    if (cnt_q != 4'd0) begin
      bit_o.valid = 1'b1;
      sh_d  = {sh_q[6:0], 1'b0};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1 && last_q) begin
        fin_d = 1'b1;
      end
    end else if (byte_valid_i && byte_ready_o) begin
      sh_d   = byte_i;
      cnt_d  = 4'd8;
      last_d = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      cnt_q  <= '0;
      last_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      sh_q   <= sh_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
      fin_q  <= fin_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hspp_parser.sv =====
// bit-serial sps field parser with exp-golomb decoding and result formatting
`default_nettype none

module hspp_parser import hspp_pkg::*; #(
  parameter int unsigned UE_MAX_ZEROS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bit_t        bit_i,
  input  wire logic        clear_i,
  input  wire logic [13:0] max_width_i,
  input  wire logic [13:0] max_height_i,
  output result_t          result_o
);

  localparam int unsigned CW = UE_MAX_ZEROS + 1;
  localparam int unsigned ZW = $clog2(UE_MAX_ZEROS + 2);
  localparam int unsigned MW = (CW > 10) ? CW : 10;

  phase_e          phase_q, phase_d;
  logic [2:0]      fix_cnt_q, fix_cnt_d;
  logic [7:0]      fix_sh_q, fix_sh_d;
  logic [ZW-1:0]   zrun_q, zrun_d;
  logic            in_sfx_q, in_sfx_d;
  logic [ZW-1:0]   sfx_left_q, sfx_left_d;
  logic [CW-1:0]   code_q, code_d;
  logic [7:0]      profile_q, profile_d;
  logic [7:0]      level_q, level_d;
  logic [CW-1:0]   cols_q, cols_d;
  logic [CW-1:0]   rows_q, rows_d;
  status_e         err_q, err_d;
  logic [3:0]      bcnt_q, bcnt_d;

  logic [CW-1:0]   code_next;
  logic [7:0]      byte_next;
  logic            ue_fin;
  logic [CW-1:0]   ue_val;
  logic            ue_phase;

  // ue values are kept as value plus one, the leading one of the code
  always_comb begin
    phase_d    = phase_q;
    fix_cnt_d  = fix_cnt_q;
    fix_sh_d   = fix_sh_q;
    zrun_d     = zrun_q;
    in_sfx_d   = in_sfx_q;
    sfx_left_d = sfx_left_q;
    code_d     = code_q;
    profile_d  = profile_q;
    level_d    = level_q;
    cols_d     = cols_q;
    rows_d     = rows_q;
    err_d      = err_q;
    bcnt_d     = bcnt_q;
    code_next  = {code_q[CW-2:0], bit_i.value};
    byte_next  = {fix_sh_q[6:0], bit_i.value};
    ue_fin     = 1'b0;
    ue_val     = code_next;
    ue_phase   = 1'b0;
    if (clear_i) begin
      phase_d    = PH_HDR;
      fix_cnt_d  = '0;
      fix_sh_d   = '0;
      zrun_d     = '0;
      in_sfx_d   = 1'b0;
      sfx_left_d = '0;
      code_d     = '0;
      profile_d  = '0;
      level_d    = '0;
      cols_d     = '0;
      rows_d     = '0;
      err_d      = ST_OK;
      bcnt_d     = '0;
    end else if (bit_i.valid) begin
      if (bit_i.byte_end && bcnt_q <= SHORT_BYTES) begin
        bcnt_d = bcnt_q + 4'd1;
      end
      unique case (phase_q)
        PH_HDR, PH_PROFILE, PH_FLAGS, PH_LEVEL: begin
          fix_sh_d  = byte_next;
          fix_cnt_d = fix_cnt_q + 3'd1;
          if (fix_cnt_q == 3'd7) begin
            phase_d = phase_e'(4'(phase_q) + 4'd1);
            if (phase_q == PH_PROFILE) begin
              profile_d = byte_next;
            end
            if (phase_q == PH_LEVEL) begin
              level_d = byte_next;
              if (high_profile(profile_q)) begin
                err_d   = ST_UNSUP;
                phase_d = PH_DONE;
              end
            end
          end
        end
        PH_GAPS: begin
          phase_d = PH_MB_W;
        end
        PH_SPS_ID, PH_LOG2FN, PH_POC_TYPE, PH_POC_LSB, PH_NUM_REF, PH_MB_W,
        PH_MB_H: begin
          ue_phase = 1'b1;
        end
        PH_DONE: begin
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
      if (ue_phase) begin
        if (!in_sfx_q) begin
          if (!bit_i.value) begin
            zrun_d = zrun_q + ZW'(1);
            if (zrun_q == ZW'(UE_MAX_ZEROS)) begin
              err_d   = ST_CODE;
              phase_d = PH_DONE;
            end
          end else if (zrun_q == '0) begin
            ue_fin = 1'b1;
            ue_val = CW'(1);
          end else begin
            in_sfx_d   = 1'b1;
            sfx_left_d = zrun_q;
            code_d     = CW'(1);
          end
        end else begin
          code_d     = code_next;
          sfx_left_d = sfx_left_q - ZW'(1);
          if (sfx_left_q == ZW'(1)) begin
            ue_fin = 1'b1;
          end
        end
      end
      if (ue_fin) begin
        zrun_d     = '0;
        in_sfx_d   = 1'b0;
        sfx_left_d = '0;
        priority case (phase_q)
          PH_POC_TYPE: begin
            if (ue_val == CW'(1)) begin
              phase_d = PH_POC_LSB;
            end else if (ue_val == CW'(3)) begin
              phase_d = PH_NUM_REF;
            end else begin
              err_d   = ST_UNSUP;
              phase_d = PH_DONE;
            end
          end
          PH_MB_W: begin
            cols_d  = ue_val;
            phase_d = PH_MB_H;
          end
          PH_MB_H: begin
            rows_d  = ue_val;
            phase_d = PH_DONE;
          end
          default: begin
            phase_d = phase_e'(4'(phase_q) + 4'd1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR;
      fix_cnt_q  <= '0;
      fix_sh_q   <= '0;
      zrun_q     <= '0;
      in_sfx_q   <= 1'b0;
      sfx_left_q <= '0;
      code_q     <= '0;
      profile_q  <= '0;
      level_q    <= '0;
      cols_q     <= '0;
      rows_q     <= '0;
      err_q      <= ST_OK;
      bcnt_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      fix_cnt_q  <= fix_cnt_d;
      fix_sh_q   <= fix_sh_d;
      zrun_q     <= zrun_d;
      in_sfx_q   <= in_sfx_d;
      sfx_left_q <= sfx_left_d;
      code_q     <= code_d;
      profile_q  <= profile_d;
      level_q    <= level_d;
      cols_q     <= cols_d;
      rows_q     <= rows_d;
      err_q      <= err_d;
      bcnt_q     <= bcnt_d;
    end
  end

  logic [MW-1:0] cols_ext, rows_ext, lim_w, lim_h;
  status_e       status;

  assign cols_ext = MW'(cols_q);
  assign rows_ext = MW'(rows_q);
  // size * 16 > max exactly when size > max / 16
  assign lim_w    = MW'(max_width_i[13:4]);
  assign lim_h    = MW'(max_height_i[13:4]);

  always_comb begin
    priority if (bcnt_q <= SHORT_BYTES) begin
      status = ST_SHORT;
    end else if (err_q != ST_OK) begin
      status = err_q;
    end else if (phase_q != PH_DONE) begin
      status = ST_CODE;
    end else begin
      status = ST_OK;
    end
    result_o.status  = status;
    result_o.level   = (status == ST_SHORT) ? 8'd0 : level_q;
    result_o.profile = (status == ST_SHORT) ? 8'd0 : profile_q;
    result_o.width   = (status == ST_OK && cols_ext <= lim_w) ?
                       {cols_ext[9:0], 4'b0000} : 14'd0;
    result_o.height  = (status == ST_OK && rows_ext <= lim_h) ?
                       {rows_ext[9:0], 4'b0000} : 14'd0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/h264_sps_size_parser_core.sv =====
// top level of the h264 sps picture size parser
`default_nettype none

`include "h264_sps_size_parser_core_defines.svh"

// Parses one H.264 sequence parameter set given as NAL bytes (emulation
// prevention removed), one byte per transaction with tlast on the final byte,
// and returns one result transaction per set: width and height in pixels,
// level, profile and a status. Each byte is loaded into the input shift
// register and its eight bits are then fed, one per cycle, to the serial
// parser; the byte after tlast also waits while the result is loaded into
// the output register, and for as long as that register is still held.
// No clearing pass after reset.
module h264_sps_size_parser_core import hspp_pkg::*; #(
  parameter int unsigned UE_MAX_ZEROS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // sps_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // width, height, level, profile, zero pad
  output logic [1:0]       m_axis_tuser,   // status
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [13:0] cfg_wdata_i
);

  logic [13:0] max_width_q, max_height_q;
  bit_t        feed_bit;
  logic        fin_valid, fin_ready, fin_take;
  result_t     parse_res;
  result_t     out_q;
  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q  <= MAX_WIDTH_RST;
      max_height_q <= MAX_HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_MAX_WIDTH) begin
        max_width_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == CFG_MAX_HEIGHT) begin
        max_height_q <= cfg_wdata_i;
      end
    end
  end

  hspp_bit_feed u_feed (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .bit_o        (feed_bit),
    .fin_valid_o  (fin_valid),
    .fin_ready_i  (fin_ready)
  );

  assign fin_ready = !out_valid_q || m_axis_tready;
  assign fin_take  = fin_valid && fin_ready;

  hspp_parser #(
    .UE_MAX_ZEROS (UE_MAX_ZEROS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bit_i        (feed_bit),
    .clear_i      (fin_take),
    .max_width_i  (max_width_q),
    .max_height_i (max_height_q),
    .result_o     (parse_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (fin_take) begin
        out_valid_q <= 1'b1;
        out_q       <= parse_res;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.profile, out_q.level, out_q.height, out_q.width};
  assign m_axis_tuser  = out_q.status;

  `HSPP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `HSPP_ASSERT_NEXT(a_fin_loads_output, clk_i, rst_ni, fin_take, m_axis_tvalid)
  `HSPP_ASSERT_NOW(a_error_no_size, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[27:0] == 28'd0)
  `HSPP_ASSERT_NOW(a_short_all_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ST_SHORT, m_axis_tdata == 48'd0)

endmodule

`default_nettype wire

// ===== bench/h264_sps_size_parser_core_tb.sv =====
// self-checking testbench for the h264 sps picture size parser core
`default_nettype none

module h264_sps_size_parser_core_tb;
  import hspp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PREFIX_ZEROS = 16;
  localparam logic [7:0] CHROMA_PROFILES [13] = '{
    8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
    8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sps_item_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // width, height, level, profile, zero pad
  logic [1:0]  m_axis_tuser;   // status
  logic        cfg_we_i      = 1'b0;
  logic        cfg_addr_i    = 1'b0;
  logic [13:0] cfg_wdata_i   = '0;

  h264_sps_size_parser_core #(
    .UE_MAX_ZEROS(MAX_PREFIX_ZEROS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // parser state mirror
  logic [13:0] lim_w = MAX_WIDTH_RST;
  logic [13:0] lim_h = MAX_HEIGHT_RST;
  phase_e      sps_phase;
  logic [3:0]  sps_count;
  logic [3:0]  sps_fixed_left;
  logic [4:0]  sps_zeros;
  logic [4:0]  sps_suffix_left;
  logic [16:0] sps_code;
  logic        sps_in_suffix;
  logic [7:0]  sps_profile;
  logic [7:0]  sps_level;
  logic [16:0] sps_poc;
  logic [16:0] sps_cols;
  logic [16:0] sps_rows;
  status_e     sps_err;

  sps_item_t   sps_bytes_q[$];
  result_t     expected_sizes_q[$];
  bit          stream_bits[$];
  sps_item_t   next_item;
  result_t     got_size;
  result_t     want_size;
  int unsigned queued_bytes   = 0;
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_idle_pct   = 0;
  int unsigned src_gap;
  int unsigned snk_gap;

  function automatic bit is_chroma_profile(input logic [7:0] p);
    bit hit;
    hit = 1'b0;
    foreach (CHROMA_PROFILES[k]) if (CHROMA_PROFILES[k] == p) hit = 1'b1;
    return hit;
  endfunction

  function automatic void clear_sps_state();
    sps_phase       = PH_HDR;
    sps_count       = '0;
    sps_fixed_left  = 4'd8;
    sps_zeros       = '0;
    sps_suffix_left = '0;
    sps_code        = '0;
    sps_in_suffix   = 1'b0;
    sps_profile     = '0;
    sps_level       = '0;
    sps_poc         = '0;
    sps_cols        = '0;
    sps_rows        = '0;
    sps_err         = ST_OK;
  endfunction

  function automatic void close_ue_code(input logic [16:0] v);
    sps_zeros       = '0;
    sps_suffix_left = '0;
    sps_code        = '0;
    sps_in_suffix   = 1'b0;
    case (sps_phase)
      PH_POC_TYPE: begin
        sps_poc = v;
        if (v == 17'd0) sps_phase = PH_POC_LSB;
        else if (v == 17'd2) sps_phase = PH_NUM_REF;
        else begin
          sps_err   = ST_UNSUP;
          sps_phase = PH_DONE;
        end
      end
      PH_MB_W: begin
        sps_cols  = v;
        sps_phase = PH_MB_H;
      end
      PH_MB_H: begin
        sps_rows  = v;
        sps_phase = PH_DONE;
      end
      default: sps_phase = phase_e'(sps_phase + 4'd1);
    endcase
  endfunction

  function automatic void parse_sps_bit(input logic b);
    if (sps_phase <= PH_LEVEL) begin
      sps_code = {sps_code[15:0], b};
      sps_fixed_left = sps_fixed_left - 4'd1;
      if (sps_fixed_left == 4'd0) begin
        if (sps_phase == PH_PROFILE) sps_profile = sps_code[7:0];
        if (sps_phase == PH_LEVEL) sps_level = sps_code[7:0];
        if (sps_phase == PH_LEVEL && is_chroma_profile(sps_profile)) begin
          sps_err   = ST_UNSUP;
          sps_phase = PH_DONE;
        end else begin
          sps_phase = phase_e'(sps_phase + 4'd1);
        end
        sps_code       = '0;
        sps_fixed_left = 4'd8;
      end
    end else if (sps_phase == PH_GAPS) begin
      sps_phase = PH_MB_W;
    end else if (sps_phase < PH_DONE) begin
      if (!sps_in_suffix) begin
        if (!b) begin
          sps_zeros = sps_zeros + 5'd1;
          if (sps_zeros > MAX_PREFIX_ZEROS) begin
            sps_err   = ST_CODE;
            sps_phase = PH_DONE;
          end
        end else if (sps_zeros == 5'd0) begin
          close_ue_code(17'd0);
        end else begin
          sps_in_suffix   = 1'b1;
          sps_suffix_left = sps_zeros;
          sps_code        = '0;
        end
      end else begin
        sps_code = {sps_code[15:0], b};
        sps_suffix_left = sps_suffix_left - 5'd1;
        if (sps_suffix_left == 5'd0)
          close_ue_code((17'd1 << sps_zeros) - 17'd1 + sps_code);
      end
    end
  endfunction

  function automatic void parse_sps_byte(input logic [7:0] b, input logic is_last);
    result_t     r;
    logic [21:0] px_w;
    logic [21:0] px_h;
    for (int i = 7; i >= 0; i--) parse_sps_bit(b[i]);
    if (sps_count < 4'd9) sps_count = sps_count + 4'd1;
    if (is_last) begin
      r = '0;
      if (sps_count <= SHORT_BYTES) begin
        r.status = ST_SHORT;
      end else begin
        r.level   = sps_level;
        r.profile = sps_profile;
        if (sps_err != ST_OK) r.status = sps_err;
        else if (sps_phase != PH_DONE) r.status = ST_CODE;
        else r.status = ST_OK;
        if (r.status == ST_OK) begin
          px_w = ({5'd0, sps_cols} + 22'd1) << 4;
          px_h = ({5'd0, sps_rows} + 22'd1) << 4;
          r.width  = (px_w > {8'd0, lim_w}) ? 14'd0 : px_w[13:0];
          r.height = (px_h > {8'd0, lim_h}) ? 14'd0 : px_h[13:0];
        end
      end
      expected_sizes_q.push_back(r);
      clear_sps_state();
    end
  endfunction

  // stream building
  function automatic void put_bits(input int unsigned v, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endfunction

  function automatic void put_ue(input int unsigned v);
    int unsigned n;
    n = $clog2(v + 2) - 1;
    put_bits(0, n);
    put_bits(v + 1, n + 1);
  endfunction

  function automatic void put_head(input int unsigned prof);
    put_bits($urandom_range(0, 1) ? 8'h67 : $urandom_range(0, 255), 8);
    put_bits(prof, 8);
    put_bits($urandom_range(0, 255), 8);
    put_bits($urandom_range(0, 255), 8);
  endfunction

  function automatic void build_sps(input int unsigned prof, input int unsigned poc,
                                    input int unsigned mbw, input int unsigned mbh,
                                    input bit wide_codes);
    put_head(prof);
    put_ue(wide_codes ? $urandom_range(1000, 131070) : $urandom_range(0, 31));
    put_ue(wide_codes ? $urandom_range(1000, 131070) : $urandom_range(0, 12));
    put_ue(poc);
    if (poc == 0) put_ue(wide_codes ? $urandom_range(1000, 131070) : $urandom_range(0, 12));
    put_ue(wide_codes ? $urandom_range(1000, 131070) : $urandom_range(0, 16));
    put_bits($urandom_range(0, 1), 1);
    put_ue(mbw);
    put_ue(mbh);
  endfunction

  function automatic int unsigned fit_bytes();
    int unsigned nb;
    nb = (stream_bits.size() + 7) / 8;
    return (nb < 9) ? 9 : nb;
  endfunction

  function automatic void send_stream(input int unsigned nbytes);
    sps_item_t it;
    while (stream_bits.size() < nbytes * 8) stream_bits.push_back($urandom_range(0, 1));
    for (int k = 0; k < int'(nbytes); k++) begin
      for (int i = 0; i < 8; i++) it.data[7-i] = stream_bits[k*8+i];
      it.last = (k == int'(nbytes) - 1);
      sps_bytes_q.push_back(it);
    end
    stream_bits.delete();
    queued_bytes += nbytes;
  endfunction

  function automatic int unsigned pick_mb(input logic [13:0] lim);
    case ($urandom_range(0, 9))
      6: return (lim >= 14'd16) ? lim / 16 - 1 : 0;
      7: return lim / 16;
      8: return $urandom_range(0, 600);
      9: return $urandom_range(0, 131070);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic int unsigned pick_plain_profile();
    case ($urandom_range(0, 3))
      0: return 66;
      1: return 77;
      2: return 88;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int unsigned pick_bad_poc();
    case ($urandom_range(0, 2))
      0: return 1;
      1: return $urandom_range(3, 30);
      default: return $urandom_range(31, 131070);
    endcase
  endfunction

  function automatic void gen_stream();
    int unsigned kind;
    int unsigned prof;
    int unsigned nb;
    int unsigned hend;
    kind = $urandom_range(0, 99);
    prof = pick_plain_profile();
    if (kind < 60) begin
      build_sps(prof, $urandom_range(0, 1) ? 0 : 2, pick_mb(lim_w), pick_mb(lim_h), 1'b0);
      nb = fit_bytes() + $urandom_range(0, 2);
    end else if (kind < 68) begin
      build_sps(prof, pick_bad_poc(), pick_mb(lim_w), pick_mb(lim_h), 1'b0);
      nb = fit_bytes() + $urandom_range(0, 1);
    end else if (kind < 74) begin
      put_head(CHROMA_PROFILES[$urandom_range(0, 12)]);
      nb = $urandom_range(9, 12);
    end else if (kind < 80) begin
      put_head(prof);
      repeat ($urandom_range(0, 4)) put_ue($urandom_range(0, 20));
      put_bits(0, $urandom_range(MAX_PREFIX_ZEROS + 1, MAX_PREFIX_ZEROS + 8));
      nb = fit_bytes() + $urandom_range(0, 1);
    end else if (kind < 88) begin
      build_sps(prof, $urandom_range(0, 1) ? 0 : 2, pick_mb(lim_w), pick_mb(lim_h), 1'b1);
      hend = stream_bits.size();
      nb = $urandom_range(9, (hend - 1) / 8);
    end else if (kind < 94) begin
      build_sps(prof, 0, pick_mb(lim_w), pick_mb(lim_h), 1'b0);
      nb = $urandom_range(1, 8);
    end else begin
      nb = $urandom_range(1, 20);
    end
    send_stream(nb);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic set_size_limits(input logic [13:0] w, input logic [13:0] h);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_MAX_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_MAX_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_w = w;
    lim_h = h;
  endtask

  task automatic drain_results();
    while (sps_bytes_q.size() != 0 || s_axis_tvalid || expected_sizes_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    clear_sps_state();
  end

  // byte source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_sps_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0 || sps_bytes_q.size() == 0) begin
          if (src_gap > 0) src_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          next_item = sps_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.data;
          s_axis_tlast  <= next_item.last;
          if ($urandom_range(0, 99) < src_idle_pct) src_gap = $urandom_range(1, 4);
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_size.width   = m_axis_tdata[13:0];
        got_size.height  = m_axis_tdata[27:14];
        got_size.level   = m_axis_tdata[35:28];
        got_size.profile = m_axis_tdata[43:36];
        got_size.status  = status_e'(m_axis_tuser);
        if (expected_sizes_q.size() == 0) begin
          if (mismatch_count < 10) $display("%0t: result transaction with none pending", $time);
          mismatch_count++;
        end else begin
          want_size = expected_sizes_q.pop_front();
          check_field("width", want_size.width, got_size.width);
          check_field("height", want_size.height, got_size.height);
          check_field("level", want_size.level, got_size.level);
          check_field("profile", want_size.profile, got_size.profile);
          check_field("status", want_size.status, got_size.status);
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < snk_idle_pct) snk_gap = $urandom_range(1, 4);
      end
    end
  end

  initial begin
    int unsigned p;
    int unsigned phase_start;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    src_idle_pct = 25;
    snk_idle_pct = 25;

    // too short, a single byte
    send_stream(1);
    // exactly at the reset limits, then one macroblock row over
    build_sps(66, 0, 39, 29, 1'b0);
    send_stream(fit_bytes());
    build_sps(77, 2, 39, 30, 1'b0);
    send_stream(fit_bytes());
    // profile with chroma format fields
    put_head(100);
    send_stream(9);
    // poc type 1
    build_sps(77, 1, 10, 10, 1'b0);
    send_stream(fit_bytes());
    // prefix one zero past the bound
    put_head(66);
    put_ue(0);
    put_bits(0, MAX_PREFIX_ZEROS + 1);
    send_stream(9);

    for (p = 0; p < 6; p++) begin
      case (p)
        1: begin
          set_size_limits(14'd8192, 14'd8192);
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        2: begin
          set_size_limits(14'd0, 14'd0);
          src_idle_pct = 40;
          snk_idle_pct = 40;
        end
        3: begin
          set_size_limits(14'(16 * $urandom_range(1, 120)), 14'(16 * $urandom_range(1, 90)));
          src_idle_pct = 20;
          snk_idle_pct = 30;
        end
        4: begin
          set_size_limits(14'($urandom_range(0, 8192)), 14'($urandom_range(0, 8192)));
          src_idle_pct = 50;
          snk_idle_pct = 50;
        end
        5: begin
          set_size_limits(14'd1280, 14'd720);
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        default: ;
      endcase
      phase_start = queued_bytes;
      while (queued_bytes - phase_start < 215) gen_stream();
      drain_results();
    end

    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && expected_sizes_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
